// ===== rtl/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg: shared types and constants of the touch message decoder
// Word layouts of the three channels, stored state, register indexes
// and the message and result codes.
// ----------------------------------------------------------------------------
package tmd_pkg;

   // request function codes
   localparam logic [1:0] FUNC_MESSAGE     = 2'd0;
   localparam logic [1:0] FUNC_CLEAR_CRC   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR_RESET = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_OTHER_ID  = 3'd1;
   localparam logic [2:0] KIND_COMMAND   = 3'd2;
   localparam logic [2:0] KIND_TOUCH     = 3'd3;
   localparam logic [2:0] KIND_TOUCH_IGN = 3'd4;
   localparam logic [2:0] KIND_CONTROL   = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_COMMAND_ID  = 2'd0;
   localparam logic [1:0] CSR_TOUCH_FIRST = 2'd1;
   localparam logic [1:0] CSR_TOUCH_LAST  = 2'd2;

   // message constants
   localparam logic [7:0] NO_MSG_ID        = 8'hFF;
   localparam int unsigned STATUS_RESET_BIT = 7;
   localparam logic [7:0] TYPE_MASK        = 8'h70;
   localparam logic [7:0] EVENT_MASK       = 8'h0F;

   // touch object types that produce an event
   localparam logic [2:0] TYPE_FINGER  = 3'd1;
   localparam logic [2:0] TYPE_STYLUS  = 3'd2;
   localparam logic [2:0] TYPE_HOVER   = 3'd4;
   localparam logic [2:0] TYPE_GLOVE   = 3'd5;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] msg_id;
      logic [7:0] status_byte;
      logic [7:0] payload_b2;
      logic [7:0] payload_b3;
      logic [7:0] payload_b4;
      logic [7:0] payload_b5;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        consumed;
      logic [7:0]  touch_id;
      logic [3:0]  touch_event;
      logic [15:0] touch_x;
      logic [15:0] touch_y;
      logic [23:0] device_crc;
      logic [7:0]  device_status;
      logic        crc_done;
      logic        reset_done;
      logic        status_changed;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0] index;
      logic [7:0] data;
   } csr_word_type;

   typedef struct packed {
      logic [7:0] command_id;
      logic [7:0] touch_first_id;
      logic [7:0] touch_last_id;
   } cfg_type;

   typedef struct packed {
      logic [23:0] crc;
      logic [7:0]  status;
      logic        crc_wait;
      logic        reset_wait;
   } dev_state_type;

endpackage

// ===== rtl/tmd_if.sv =====
// ----------------------------------------------------------------------------
// tmd_if: valid/ready channels of the touch message decoder
// Request, response and configuration channels, each with a source
// and a sink modport.
// ----------------------------------------------------------------------------
interface tmd_req_if import tmd_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tmd_rsp_if import tmd_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tmd_csr_if import tmd_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/touch_message_decoder_top.sv =====
// ----------------------------------------------------------------------------
// touch_message_decoder_top: touch-controller message decoder
// Decodes controller messages into command status and touch events.
//
// Usage:
//   req_chan  request words: a function code and one six-byte message.
//   rsp_chan  one response word per request word, in order.
//   csr_chan  register writes (command id, first and last touch id);
//             always ready; the user writes only while no request is in
//             flight; the block does not enforce it.
// Timing: an accepted request word sits in the input register, is decoded,
//   lands in the response register; one word per cycle is sustained while
//   rsp_chan.ready is high. Device state (CRC, status, wait flags) updates
//   as a word enters the response register, so later words see its effects.
// Stalls: while rsp_chan.ready is low the response register holds and the
//   input register still takes one more word; then req_chan.ready drops.
// Reset: synchronous, active high; empties both pipeline registers and
//   clears the device state and the configuration registers to zero.
// ----------------------------------------------------------------------------
module touch_message_decoder_top import tmd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tmd_req_if.sink   req_chan,
   tmd_rsp_if.source rsp_chan,
   tmd_csr_if.sink   csr_chan
);

   cfg_type       cfg;
   req_word_type  in_word_ff;
   req_word_type  in_word_in;
   logic          in_valid_ff;
   logic          in_valid_in;
   rsp_word_type  out_word_ff;
   rsp_word_type  out_word_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   dev_state_type dev_ff;
   dev_state_type dev_in;
   dev_state_type dev_nxt;
   rsp_word_type  dec_word;
   logic          advance;
   logic          req_take;

   // configuration registers
   assign csr_chan.ready = 1'b1;

   tmd_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_chan.valid),
      .wr_word (csr_chan.payload),
      .cfg     (cfg)
   );

   // decode between input and response registers
   tmd_decode u_decode (
      .req (in_word_ff),
      .cfg (cfg),
      .cur (dev_ff),
      .rsp (dec_word),
      .nxt (dev_nxt)
   );

   // pipeline flow control
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_word_in   = req_take ? req_chan.payload : in_word_ff;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_word_in  = advance ? dec_word : out_word_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      dev_in       = advance ? dev_nxt : dev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         dev_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         dev_ff       <= dev_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

   // checks
   a_clear_crc: assert property (@(posedge clock) disable iff (reset)
      (advance && in_word_ff.func == FUNC_CLEAR_CRC) |=>
         (dev_ff.crc == '0 && !dev_ff.crc_wait))
      else $error("CRC clear did not take effect");

   a_consumed_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.consumed ==
         (rsp_chan.payload.kind == KIND_OTHER_ID || rsp_chan.payload.kind == KIND_COMMAND ||
          rsp_chan.payload.kind == KIND_TOUCH || rsp_chan.payload.kind == KIND_TOUCH_IGN)))
      else $error("consumed flag disagrees with kind");

   a_state_mirror: assert property (@(posedge clock) disable iff (reset)
      $past(advance) |-> (rsp_chan.payload.device_crc == dev_ff.crc &&
         rsp_chan.payload.device_status == dev_ff.status &&
         rsp_chan.payload.crc_done == dev_ff.crc_wait &&
         rsp_chan.payload.reset_done == dev_ff.reset_wait))
      else $error("response state differs from stored device state");

   a_changed_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.status_changed) |->
         (rsp_chan.payload.kind == KIND_COMMAND))
      else $error("status change flagged outside a command status word");

endmodule

// ===== rtl/tmd_csr_regs.sv =====
// ----------------------------------------------------------------------------
// tmd_csr_regs: configuration registers
// Holds the command report id and the touch id range; one write per word.
// ----------------------------------------------------------------------------
module tmd_csr_regs import tmd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  csr_word_type wr_word,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode; index 3 is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_word.index)
            CSR_COMMAND_ID:  cfg_in.command_id     = wr_word.data;
            CSR_TOUCH_FIRST: cfg_in.touch_first_id = wr_word.data;
            CSR_TOUCH_LAST:  cfg_in.touch_last_id  = wr_word.data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tmd_decode.sv =====
// ----------------------------------------------------------------------------
// tmd_decode: message decode logic
// Classifies one request word against the configuration, builds the
// response word and the next device state.
// ----------------------------------------------------------------------------
module tmd_decode import tmd_pkg::*; (
   input  req_word_type  req,
   input  cfg_type       cfg,
   input  dev_state_type cur,
   output rsp_word_type  rsp,
   output dev_state_type nxt
);

   logic       is_command;
   logic       in_range;
   logic       is_screen_id;
   logic       type_ok;
   logic [8:0] first_plus2;
   logic [2:0] touch_type;
   logic [7:0] type_bits;

   // id matching and touch type check
   always_comb begin
      first_plus2  = {1'b0, cfg.touch_first_id} + 9'd2;
      is_command   = (req.msg_id == cfg.command_id);
      in_range     = (req.msg_id >= cfg.touch_first_id) &&
                     (req.msg_id <= cfg.touch_last_id);
      is_screen_id = ({1'b0, req.msg_id} < first_plus2);
      type_bits    = (req.status_byte & TYPE_MASK) >> 4;
      touch_type   = type_bits[2:0];
      unique case (touch_type)
         TYPE_FINGER, TYPE_STYLUS, TYPE_HOVER, TYPE_GLOVE: type_ok = 1'b1;
         default:                                          type_ok = 1'b0;
      endcase
   end

   // response and state update
   always_comb begin
      rsp = '0;
      nxt = cur;
      unique case (req.func)
         FUNC_CLEAR_CRC: begin
            nxt.crc      = '0;
            nxt.crc_wait = 1'b0;
            rsp.kind     = KIND_CONTROL;
         end
         FUNC_CLEAR_RESET: begin
            nxt.reset_wait = 1'b0;
            rsp.kind       = KIND_CONTROL;
         end
         FUNC_MESSAGE: begin
            if (req.msg_id != NO_MSG_ID) begin
               rsp.consumed = 1'b1;
               priority if (is_command) begin
                  nxt.crc      = {req.payload_b4, req.payload_b3, req.payload_b2};
                  nxt.crc_wait = 1'b1;
                  if (req.status_byte[STATUS_RESET_BIT]) begin
                     nxt.reset_wait = 1'b1;
                  end
                  rsp.status_changed = (req.status_byte != cur.status);
                  nxt.status         = req.status_byte;
                  rsp.kind           = KIND_COMMAND;
               end else if (in_range) begin
                  if (!is_screen_id && type_ok) begin
                     rsp.kind        = KIND_TOUCH;
                     rsp.touch_id    = req.msg_id - first_plus2[7:0];
                     rsp.touch_event = req.status_byte[3:0] & EVENT_MASK[3:0];
                     rsp.touch_x     = {req.payload_b3, req.payload_b2};
                     rsp.touch_y     = {req.payload_b5, req.payload_b4};
                  end else begin
                     rsp.kind = KIND_TOUCH_IGN;
                  end
               end else begin
                  rsp.kind = KIND_OTHER_ID;
               end
            end
         end
         default: rsp.kind = KIND_NONE;
      endcase
      rsp.device_crc    = nxt.crc;
      rsp.device_status = nxt.status;
      rsp.crc_done      = nxt.crc_wait;
      rsp.reset_done    = nxt.reset_wait;
   end

endmodule
